>>> rtl/core/lidar_point_camera_projection_assert.svh
// assertion macros for the lidar point camera projection block
// used by the port checker; expects clk and arst_n in scope
`ifndef LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_ASSERT_SVH

// condition holds at every edge out of reset
`define LPCP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lpcp assertion failed");

// antecedent implies consequent in the same cycle
`define LPCP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpcp assertion failed");

`endif

>>> rtl/core/lpcp_pkg.sv
// types and constants for the lidar point camera projection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lpcp_pkg;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] pixel_u;
		logic signed [23:0] pixel_v;
	} result_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NEAR = 2'd1;
	localparam logic [1:0] ST_FAR  = 2'd2;

	localparam logic [2:0] REG_ROT_X     = 3'd0;
	localparam logic [2:0] REG_ROT_Y     = 3'd1;
	localparam logic [2:0] REG_ROT_Z     = 3'd2;
	localparam logic [2:0] REG_TRANS     = 3'd3;
	localparam logic [2:0] REG_FOCAL     = 3'd4;
	localparam logic [2:0] REG_PRINCIPAL = 3'd5;
	localparam logic [2:0] REG_DEPTH     = 3'd6;

	localparam int QW          = 27;
	localparam int LPCP_LATENCY = 33;

	localparam logic [23:0] UNIT_FOCAL = 24'd256;
	localparam logic signed [23:0] PIX_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] PIX_MIN = 24'sh800000;

endpackage
`default_nettype wire

>>> rtl/core/lidar_point_camera_projection.sv
// lidar point camera projection, top level: config registers, rigid transform,
// depth window check and two projection axes; uses lpcp_pkg and lpcp_axis
//
// usage:
//   a point is taken on each clock edge where start is high and busy is low;
//   busy stays low, so a new point may enter every cycle
//   each point gives one result, shown for one cycle with result_valid high;
//   status tells projected, too near or too far, and rejected points carry
//   zero pixels
//   throughput is one point per cycle; latency is set by three transform
//   stages, two focal scaling stages, one stage per quotient bit of the
//   27-bit depth divider and one output stage
//   the receiver cannot stall; results are never held back
//   registers are written through cfg_we, cfg_index and cfg_data; the user must
//   write them only while no point is in flight, the block does not enforce it
//   reset clears all in-flight transactions and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module lidar_point_camera_projection import lpcp_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  point_t      point,
	output logic        result_valid,
	output result_t     result,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_index,
	input  wire [59:0]  cfg_data
);

	logic [47:0] rot_x_q, rot_y_q, rot_z_q, focal_q, principal_q, depth_q;
	logic [59:0] trans_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q     <= 48'h000040000000;
			rot_y_q     <= 48'h000000004000;
			rot_z_q     <= '0;
			trans_q     <= '0;
			focal_q     <= '0;
			principal_q <= '0;
			depth_q     <= 48'd87968926000000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_X:     rot_x_q     <= cfg_data[47:0];
				REG_ROT_Y:     rot_y_q     <= cfg_data[47:0];
				REG_ROT_Z:     rot_z_q     <= cfg_data[47:0];
				REG_TRANS:     trans_q     <= cfg_data;
				REG_FOCAL:     focal_q     <= cfg_data[47:0];
				REG_PRINCIPAL: principal_q <= cfg_data[47:0];
				REG_DEPTH:     depth_q     <= cfg_data[47:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [47:0] prod_s1 [0:8];
	logic signed [48:0] cam_x_s2, cam_y_s2, cam_z_s2;
	logic [1:0]         status_s3;
	logic [48:0]        mag_x_s3, mag_y_s3;
	logic               neg_x_s3, neg_y_s3;
	logic [37:0]        den_s3;

	logic [47:0] rows [0:2];
	logic signed [31:0] pts [0:2];

	assign rows[0] = rot_x_q;
	assign rows[1] = rot_y_q;
	assign rows[2] = rot_z_q;
	assign pts[0]  = point.point_x;
	assign pts[1]  = point.point_y;
	assign pts[2]  = point.point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// rotation products
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				prod_s1[r*3+c] <= $signed(rows[r][47-16*c -: 16]) * pts[c];
			end
		end
	end

	function automatic logic signed [48:0] cam_sum(
		input logic signed [47:0] a,
		input logic signed [47:0] b,
		input logic signed [47:0] c,
		input logic [19:0]        t
	);
		logic signed [37:0] ts;
		ts = $signed({t, 18'd0});
		return 49'(a) + 49'(b) + 49'(c) + 49'(ts);
	endfunction

	always_ff @(posedge clk) begin
		cam_x_s2 <= cam_sum(prod_s1[0], prod_s1[1], prod_s1[2], trans_q[59:40]);
		cam_y_s2 <= cam_sum(prod_s1[3], prod_s1[4], prod_s1[5], trans_q[39:20]);
		cam_z_s2 <= cam_sum(prod_s1[6], prod_s1[7], prod_s1[8], trans_q[19:0]);
	end

	// depth window and magnitudes
	logic signed [48:0] dmin, dmax;
	logic [1:0]         status_c;

	always_comb begin
		dmin = $signed({11'd0, depth_q[47:24], 14'd0});
		dmax = $signed({11'd0, depth_q[23:0], 14'd0});
		if (cam_z_s2 <= dmin) begin
			status_c = ST_NEAR;
		end else if (cam_z_s2 >= dmax) begin
			status_c = ST_FAR;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		status_s3 <= status_c;
		neg_x_s3  <= cam_x_s2[48];
		neg_y_s3  <= cam_y_s2[48];
		mag_x_s3  <= cam_x_s2[48] ? 49'(-cam_x_s2) : 49'(cam_x_s2);
		mag_y_s3  <= cam_y_s2[48] ? 49'(-cam_y_s2) : 49'(cam_y_s2);
		den_s3    <= cam_z_s2[37:0];
	end

	logic [23:0] fx, fy;
	assign fx = (focal_q[47:24] == 24'd0) ? UNIT_FOCAL : focal_q[47:24];
	assign fy = (focal_q[23:0] == 24'd0) ? UNIT_FOCAL : focal_q[23:0];

	logic               u_valid, v_valid;
	logic [1:0]         u_tag, v_tag;
	logic signed [23:0] u_pix, v_pix;

	lpcp_axis u_axis_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_tag    (status_s3),
		.in_mag    (mag_x_s3),
		.in_neg    (neg_x_s3),
		.in_den    (den_s3),
		.focal     (fx),
		.center    (principal_q[47:24]),
		.out_valid (u_valid),
		.out_tag   (u_tag),
		.out_pixel (u_pix)
	);

	lpcp_axis u_axis_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_tag    (status_s3),
		.in_mag    (mag_y_s3),
		.in_neg    (neg_y_s3),
		.in_den    (den_s3),
		.focal     (fy),
		.center    (principal_q[23:0]),
		.out_valid (v_valid),
		.out_tag   (v_tag),
		.out_pixel (v_pix)
	);

	assign result_valid   = u_valid && v_valid;
	assign result.status  = u_tag;
	assign result.pixel_u = (u_tag == ST_OK) ? u_pix : 24'sd0;
	assign result.pixel_v = (v_tag == ST_OK) ? v_pix : 24'sd0;

endmodule
`default_nettype wire

>>> rtl/core/lpcp_axis.sv
// one projection axis: scale by focal length, pipelined restoring divide by depth,
// add principal point and saturate; uses lpcp_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpcp_axis import lpcp_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire [1:0]         in_tag,
	input  wire [48:0]        in_mag,
	input  wire               in_neg,
	input  wire [37:0]        in_den,
	input  wire [23:0]        focal,
	input  wire [23:0]        center,
	output logic              out_valid,
	output logic [1:0]        out_tag,
	output logic signed [23:0] out_pixel
);

	logic        valid_s1;
	logic [1:0]  tag_s1;
	logic        neg_s1;
	logic [37:0] den_s1;
	logic [48:0] plo_s1;
	logic [47:0] phi_s1;
	logic [72:0] num;

	// partial products of magnitude times focal length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		neg_s1 <= in_neg;
		den_s1 <= in_den;
		plo_s1 <= in_mag[24:0] * focal;
		phi_s1 <= in_mag[48:25] * focal;
	end

	assign num = {phi_s1, 25'd0} + {24'd0, plo_s1};

	logic            dv_v   [0:QW];
	logic [1:0]      dv_tag [0:QW];
	logic            dv_neg [0:QW];
	logic            dv_ovf [0:QW];
	logic [37:0]     dv_den [0:QW];
	logic [37:0]     dv_rem [0:QW];
	logic [QW-1:0]   dv_low [0:QW];
	logic [QW-1:0]   dv_q   [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dv_tag[0] <= tag_s1;
		dv_neg[0] <= neg_s1;
		dv_den[0] <= den_s1;
		dv_ovf[0] <= num[72:27] >= {8'd0, den_s1};
		dv_rem[0] <= num[64:27];
		dv_low[0] <= num[26:0];
		dv_q[0]   <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [38:0] trial;
		logic [38:0] diff;
		logic        ge;

		assign trial = {dv_rem[k], dv_low[k][QW-1-k]};
		assign diff  = trial - {1'b0, dv_den[k]};
		assign ge    = trial >= {1'b0, dv_den[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_tag[k+1] <= dv_tag[k];
			dv_neg[k+1] <= dv_neg[k];
			dv_ovf[k+1] <= dv_ovf[k];
			dv_den[k+1] <= dv_den[k];
			dv_low[k+1] <= dv_low[k];
			dv_rem[k+1] <= ge ? diff[37:0] : trial[37:0];
			dv_q[k+1]   <= {dv_q[k][QW-2:0], ge};
		end
	end

	logic signed [28:0] mag;
	logic signed [28:0] sum;
	logic signed [23:0] pix;

	always_comb begin
		mag = $signed({2'b00, dv_q[QW]});
		sum = (dv_neg[QW] ? -mag : mag) + $signed({5'd0, center});
		if (dv_ovf[QW]) begin
			pix = dv_neg[QW] ? PIX_MIN : PIX_MAX;
		end else if (sum > 29'sd8388607) begin
			pix = PIX_MAX;
		end else if (sum < -29'sd8388608) begin
			pix = PIX_MIN;
		end else begin
			pix = sum[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		out_tag   <= dv_tag[QW];
		out_pixel <= pix;
	end

endmodule
`default_nettype wire

>>> rtl/core/lpcp_checker.sv
// port checker for the lidar point camera projection block and its bind
// uses lpcp_pkg and lidar_point_camera_projection_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_point_camera_projection_assert.svh"
module lpcp_port_checker import lpcp_pkg::*; (
	input wire     clk,
	input wire     arst_n,
	input wire     start,
	input wire     busy,
	input wire     result_valid,
	input result_t result
);

	logic status_known;
	logic rejected;
	logic pixels_zero;

	assign status_known = (result.status == ST_OK) || (result.status == ST_NEAR)
		|| (result.status == ST_FAR);
	assign rejected     = result_valid && (result.status != ST_OK);
	assign pixels_zero  = (result.pixel_u == 24'sd0) && (result.pixel_v == 24'sd0);

	`LPCP_ASSERT_ALWAYS(a_never_busy, !busy)
	`LPCP_ASSERT_IMPLY(a_status_code, result_valid, status_known)
	`LPCP_ASSERT_IMPLY(a_reject_zero, rejected, pixels_zero)
	`LPCP_ASSERT_IMPLY(a_result_has_transaction, result_valid, $past(start && !busy, LPCP_LATENCY))

endmodule

bind lidar_point_camera_projection lpcp_port_checker u_lpcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire
